// File: rtl/cet_pkg.sv
package cet_pkg;

    localparam int KIND_W     = 2;
    localparam int FIELD_W    = 48;
    localparam int COUNT_OUT_W = 7;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 112;

    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NOP   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PLACE,
        ST_MERGE,
        ST_SETTLE,
        ST_QUERY,
        ST_CLEAR,
        ST_REPORT
    } state_t;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_SCAN,
        CMD_INSERT,
        CMD_ABSORB,
        CMD_COLLAPSE
    } cmd_t;

    typedef struct packed {
        logic below;
        logic hit;
    } cell_flags_t;

endpackage

// File: rtl/cet_cell.sv
module cet_cell
    import cet_pkg::*;
#(
    parameter int W     = 48,
    parameter int CNT_W = 7,
    parameter int INDEX = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    input  logic [W-1:0]     s,
    input  logic [W-1:0]     e,
    input  logic [CNT_W-1:0] count,
    input  logic [W-1:0]     left_start,
    input  logic [W-1:0]     left_end,
    input  cell_flags_t      left_flags,
    input  logic [W-1:0]     right_start,
    input  logic [W-1:0]     right_end,
    input  cell_flags_t      right_flags,
    output logic [W-1:0]     start_q,
    output logic [W-1:0]     end_q,
    output cell_flags_t      flags_q,
    output logic [W-1:0]     delta,
    output logic             qhit,
    output logic [W-1:0]     room
);

    logic [W-1:0] start_reg, start_next;
    logic [W-1:0] end_reg, end_next;
    cell_flags_t  flags_reg, flags_next;
    logic         occ, lt_s, le_e, first;

    assign occ   = CNT_W'(INDEX) < count;
    assign lt_s  = end_reg < s;
    assign le_e  = start_reg <= e;
    assign first = flags_reg.hit && !left_flags.hit;

    always_comb
    begin
        start_next = start_reg;
        end_next   = end_reg;
        flags_next = flags_reg;
        delta      = '0;
        case (cmd)
            CMD_SCAN:
            begin
                flags_next.below = occ && lt_s;
                flags_next.hit   = occ && !lt_s && le_e;
            end
            CMD_INSERT:
            begin
                if (!flags_reg.below)
                begin
                    if (left_flags.below)
                    begin
                        start_next = s;
                        end_next   = e;
                    end
                    else
                    begin
                        start_next = left_start;
                        end_next   = left_end;
                    end
                end
                flags_next = '0;
            end
            CMD_ABSORB:
            begin
                if (first)
                begin
                    start_next = (start_reg < s) ? start_reg : s;
                    end_next   = (end_reg > e) ? end_reg : e;
                    delta      = (end_next - start_next) - (end_reg - start_reg);
                end
            end
            CMD_COLLAPSE:
            begin
                if (!flags_reg.below)
                begin
                    if (first)
                    begin
                        end_next = (end_reg > right_end) ? end_reg : right_end;
                        delta    = end_next - end_reg - (right_end - right_start);
                    end
                    else
                    begin
                        start_next = right_start;
                        end_next   = right_end;
                        flags_next = right_flags;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        end_reg   <= end_next;
    end

    assign qhit    = occ && (start_reg <= s) && (s < end_reg);
    assign room    = qhit ? (end_reg - s) : '0;
    assign start_q = start_reg;
    assign end_q   = end_reg;
    assign flags_q = flags_reg;

endmodule

// File: rtl/coalescing_interval_tracker.sv
// an add walks SCAN, PLACE, MERGE (while ranges merge), SETTLE, REPORT;
//   a zero-length add SCAN, REPORT; query and clear their own state, then REPORT;
// no-op goes straight to REPORT, which waits out any output stall
// throughput: one request at a time, set by the merge loop in the cell chain
// a new request is taken while the previous result still waits in the output register
// reset: asynchronous active low, table empty, byte total and file size zero
module coalescing_interval_tracker
    import cet_pkg::*;
#(
    parameter int MAX_RANGES  = 64,
    parameter int OFFSET_BITS = 48
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // position, length
    input  logic [KIND_W-1:0]     s_tuser,  // kind
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // covered, covered_length, done_bytes, range_count, finished, overflow, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [FIELD_W-1:0]    cfg_data
);

    localparam int W     = OFFSET_BITS;
    localparam int CNT_W = $clog2(MAX_RANGES + 1);
    localparam int CW    = ((OFFSET_BITS > FIELD_W) ? OFFSET_BITS : FIELD_W) + 1;
    localparam logic [W-1:0] OFF_MASK = {W{1'b1}};

    state_t state_reg, state_next;
    cmd_t   cmd;

    logic [KIND_W-1:0]     kind_reg;
    logic [FIELD_W-1:0]    pos_reg, len_reg, file_size_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [W-1:0]          total_reg, delta_reg, qroom_reg;
    logic                  qhit_reg, ovf_reg;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic [W-1:0]  s_w, e_w;
    logic [CW-1:0] sum_c;
    logic          empty, any_hit, more, full;
    logic          accept, do_insert, do_collapse, do_clear, do_load, set_ovf;
    logic [W-1:0]  delta_or, room_or;
    logic          qhit_or;
    logic [CW-1:0] cov_len_c;

    logic [W-1:0] start_q [MAX_RANGES];
    logic [W-1:0] end_q   [MAX_RANGES];
    logic [W-1:0] delta_c [MAX_RANGES];
    logic [W-1:0] room_c  [MAX_RANGES];
    cell_flags_t  flags_q [MAX_RANGES];
    logic         qhit_c  [MAX_RANGES];

    assign s_w   = W'(pos_reg);
    assign sum_c = CW'(s_w) + CW'(len_reg);
    assign e_w   = (sum_c > CW'(OFF_MASK)) ? OFF_MASK : W'(sum_c);
    assign empty = e_w <= s_w;
    assign full  = count_reg >= CNT_W'(MAX_RANGES);

    genvar g;
    generate
        for (g = 0; g < MAX_RANGES; g++)
        begin : g_cell
            logic [W-1:0] ls, le, rs, re;
            cell_flags_t  lf, rf;
            if (g == 0)
            begin : g_first
                assign ls = '0;
                assign le = '0;
                assign lf = '{below: 1'b1, hit: 1'b0};
            end
            else
            begin : g_mid
                assign ls = start_q[g-1];
                assign le = end_q[g-1];
                assign lf = flags_q[g-1];
            end
            if (g == MAX_RANGES - 1)
            begin : g_last
                assign rs = '0;
                assign re = '0;
                assign rf = '0;
            end
            else
            begin : g_inner
                assign rs = start_q[g+1];
                assign re = end_q[g+1];
                assign rf = flags_q[g+1];
            end
            cet_cell #(.W(W), .CNT_W(CNT_W), .INDEX(g)) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .s           (s_w),
                .e           (e_w),
                .count       (count_reg),
                .left_start  (ls),
                .left_end    (le),
                .left_flags  (lf),
                .right_start (rs),
                .right_end   (re),
                .right_flags (rf),
                .start_q     (start_q[g]),
                .end_q       (end_q[g]),
                .flags_q     (flags_q[g]),
                .delta       (delta_c[g]),
                .qhit        (qhit_c[g]),
                .room        (room_c[g])
            );
        end
    endgenerate

    always_comb
    begin
        any_hit  = 1'b0;
        more     = 1'b0;
        delta_or = '0;
        room_or  = '0;
        qhit_or  = 1'b0;
        for (int k = 0; k < MAX_RANGES; k++)
        begin
            any_hit  = any_hit | flags_q[k].hit;
            delta_or = delta_or | delta_c[k];
            room_or  = room_or | room_c[k];
            qhit_or  = qhit_or | qhit_c[k];
        end
        for (int k = 1; k < MAX_RANGES; k++)
        begin
            more = more | (flags_q[k].hit & flags_q[k-1].hit);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    unique case (s_tuser)
                        KIND_ADD:   state_next = ST_SCAN;
                        KIND_QUERY: state_next = ST_QUERY;
                        KIND_CLEAR: state_next = ST_CLEAR;
                        default:    state_next = ST_REPORT;
                    endcase
                end
            end
            ST_SCAN:   state_next = empty ? ST_REPORT : ST_PLACE;
            ST_PLACE:  state_next = any_hit ? ST_MERGE : ST_SETTLE;
            ST_MERGE:  state_next = more ? ST_MERGE : ST_SETTLE;
            ST_SETTLE: state_next = ST_REPORT;
            ST_QUERY:  state_next = ST_REPORT;
            ST_CLEAR:  state_next = ST_REPORT;
            ST_REPORT: state_next = (!out_valid_reg || m_tready) ? ST_IDLE : ST_REPORT;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs of the controller
    always_comb
    begin
        cmd         = CMD_HOLD;
        accept      = 1'b0;
        do_insert   = 1'b0;
        do_collapse = 1'b0;
        do_clear    = 1'b0;
        do_load     = 1'b0;
        set_ovf     = 1'b0;
        unique case (state_reg)
            ST_IDLE:  accept = s_tvalid;
            ST_SCAN:  cmd = CMD_SCAN;
            ST_PLACE:
            begin
                if (any_hit)
                begin
                    cmd = CMD_ABSORB;
                end
                else if (full)
                begin
                    set_ovf = 1'b1;
                end
                else
                begin
                    cmd       = CMD_INSERT;
                    do_insert = 1'b1;
                end
            end
            ST_MERGE:
            begin
                if (more)
                begin
                    cmd         = CMD_COLLAPSE;
                    do_collapse = 1'b1;
                end
            end
            ST_CLEAR:  do_clear = 1'b1;
            ST_REPORT: do_load = !out_valid_reg || m_tready;
            default:
            begin
            end
        endcase
    end

    assign cov_len_c = (CW'(len_reg) < CW'(qroom_reg)) ? CW'(len_reg) : CW'(qroom_reg);

    // result word
    always_comb
    begin
        out_data_next = '0;
        out_data_next[0] = qhit_reg && (kind_reg == KIND_QUERY);
        out_data_next[FIELD_W:1] = (qhit_reg && (kind_reg == KIND_QUERY))
                                   ? FIELD_W'(cov_len_c) : '0;
        out_data_next[2*FIELD_W:FIELD_W+1] = FIELD_W'(total_reg);
        out_data_next[2*FIELD_W+COUNT_OUT_W:2*FIELD_W+1] = COUNT_OUT_W'(count_reg);
        out_data_next[2*FIELD_W+COUNT_OUT_W+1] = (count_reg == CNT_W'(1))
            && (start_q[0] == '0) && (CW'(end_q[0]) == CW'(file_size_reg));
        out_data_next[2*FIELD_W+COUNT_OUT_W+2] = ovf_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            delta_reg     <= '0;
            file_size_reg <= '0;
            out_valid_reg <= 1'b0;
            ovf_reg       <= 1'b0;
            qhit_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                file_size_reg <= cfg_data;
            end
            if (do_clear)
            begin
                count_reg <= '0;
                total_reg <= '0;
                delta_reg <= '0;
            end
            else
            begin
                total_reg <= total_reg + delta_reg;
                delta_reg <= do_insert ? (e_w - s_w) : delta_or;
                if (do_insert)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                else if (do_collapse)
                begin
                    count_reg <= count_reg - CNT_W'(1);
                end
            end
            if (accept)
            begin
                ovf_reg  <= 1'b0;
                qhit_reg <= 1'b0;
            end
            else
            begin
                if (set_ovf)
                begin
                    ovf_reg <= 1'b1;
                end
                if (state_reg == ST_QUERY)
                begin
                    qhit_reg <= qhit_or && (len_reg != '0);
                end
            end
            if (do_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= s_tuser;
            pos_reg  <= s_tdata[FIELD_W-1:0];
            len_reg  <= s_tdata[IN_DATA_W-1:FIELD_W];
        end
        if (state_reg == ST_QUERY)
        begin
            qroom_reg <= room_or;
        end
        if (do_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

endmodule

// File: rtl/cet_checker.sv
module cet_checker
    import cet_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // a result waiting on the output holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // one request at a time
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // uncovered query reports zero length
    a_cov_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[FIELD_W:1] == '0)
        else $error("length without coverage");

    // finished means exactly one range
    a_finished: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2*FIELD_W+COUNT_OUT_W+1]
        |-> m_tdata[2*FIELD_W+COUNT_OUT_W:2*FIELD_W+1] == COUNT_OUT_W'(1))
        else $error("finished with range count not one");

    // an overflowed add never reports coverage
    a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2*FIELD_W+COUNT_OUT_W+2] |-> !m_tdata[0])
        else $error("overflow with coverage");

endmodule

bind coalescing_interval_tracker cet_checker u_cet_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: test/interval_checker.sv
`timescale 1ns / 100ps

module interval_checker
    import cet_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [KIND_W-1:0]     s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [FIELD_W-1:0]    cfg_data,
    output int                    fail_count,
    output int                    pending_count
);

    localparam int RANGE_SLOTS = 64;
    localparam int EXP_SLOTS   = 16;
    localparam logic [FIELD_W-1:0] OFFSET_TOP = {FIELD_W{1'b1}};

    typedef struct packed {
        logic               covered;
        logic [FIELD_W-1:0] covered_length;
        logic [FIELD_W-1:0] done_bytes;
        logic [6:0]         range_count;
        logic               finished;
        logic               overflow;
    } status_t;

    logic [FIELD_W-1:0] span_lo [RANGE_SLOTS];
    logic [FIELD_W-1:0] span_hi [RANGE_SLOTS];
    int                 span_count;
    logic [FIELD_W-1:0] byte_total;
    logic [FIELD_W-1:0] file_bytes;
    status_t            expected_status [EXP_SLOTS];
    int                 wr_total;
    int                 rd_total;

    assign pending_count = wr_total - rd_total;

    function automatic void add_span(input logic [FIELD_W-1:0] lo,
                                     input logic [FIELD_W-1:0] len,
                                     output logic dropped);
        logic [FIELD_W-1:0] hi, nlo, nhi;
        logic [FIELD_W+1:0] sum;
        int i, j, merged, k, shift;
        dropped = 1'b0;
        if (len > OFFSET_TOP - lo)
            hi = OFFSET_TOP;
        else
            hi = lo + len;
        if (hi <= lo)
            return;
        i = 0;
        while (i < span_count && span_hi[i] < lo)
            i++;
        j = i;
        while (j < span_count && span_lo[j] <= hi)
            j++;
        merged = j - i;
        if (merged == 0 && span_count >= RANGE_SLOTS) begin
            dropped = 1'b1;
            return;
        end
        nlo = lo;
        nhi = hi;
        if (merged > 0) begin
            if (span_lo[i] < nlo)
                nlo = span_lo[i];
            if (span_hi[j-1] > nhi)
                nhi = span_hi[j-1];
        end
        shift = 1 - merged;
        if (shift > 0) begin
            for (k = span_count - 1; k >= j; k--)
            begin
                span_lo[k+1] = span_lo[k];
                span_hi[k+1] = span_hi[k];
            end
        end else if (shift < 0) begin
            for (k = j; k < span_count; k++)
            begin
                span_lo[k+shift] = span_lo[k];
                span_hi[k+shift] = span_hi[k];
            end
        end
        span_lo[i] = nlo;
        span_hi[i] = nhi;
        span_count = span_count + shift;
        sum = '0;
        for (k = 0; k < span_count; k++)
            sum += span_hi[k] - span_lo[k];
        byte_total = sum[FIELD_W-1:0];
    endfunction

    function automatic status_t apply_request(input logic [KIND_W-1:0] kind,
                                              input logic [FIELD_W-1:0] pos,
                                              input logic [FIELD_W-1:0] len);
        status_t st;
        logic dropped;
        logic [FIELD_W-1:0] room;
        st = '0;
        dropped = 1'b0;
        if (kind == KIND_ADD) begin
            add_span(pos, len, dropped);
        end else if (kind == KIND_QUERY) begin
            if (len != 0) begin
                for (int k = 0; k < span_count; k++)
                begin
                    if (span_lo[k] <= pos && pos < span_hi[k]) begin
                        room = span_hi[k] - pos;
                        st.covered = 1'b1;
                        st.covered_length = len < room ? len : room;
                        break;
                    end
                end
            end
        end else if (kind == KIND_CLEAR) begin
            span_count = 0;
            byte_total = '0;
        end
        st.done_bytes = byte_total;
        st.range_count = span_count[6:0];
        st.finished = span_count == 1 && span_lo[0] == 0 && span_hi[0] == file_bytes;
        st.overflow = dropped;
        return st;
    endfunction

    function automatic status_t unpack_status(input logic [OUT_DATA_W-1:0] d);
        status_t st;
        st.covered = d[0];
        st.covered_length = d[48:1];
        st.done_bytes = d[96:49];
        st.range_count = d[103:97];
        st.finished = d[104];
        st.overflow = d[105];
        return st;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        status_t got, want;
        if (!rst_n) begin
            span_count = 0;
            byte_total = '0;
            file_bytes = '0;
            wr_total = 0;
            rd_total = 0;
            fail_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready)
                file_bytes = cfg_data;
            if (s_tvalid && s_tready) begin
                expected_status[wr_total % EXP_SLOTS] = apply_request(s_tuser,
                    s_tdata[47:0], s_tdata[95:48]);
                wr_total = wr_total + 1;
            end
            if (m_tvalid && m_tready) begin
                got = unpack_status(m_tdata);
                if (wr_total == rd_total) begin
                    $display("%0t: unexpected result %h", $time, m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_status[rd_total % EXP_SLOTS];
                    rd_total = rd_total + 1;
                    if (got !== want || m_tdata[111:106] !== '0) begin
                        $display("%0t: mismatch expected %h actual %h", $time, want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import cet_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [KIND_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [FIELD_W-1:0]    cfg_data;
    int                    fail_count;
    int                    pending_count;
    bit                    hold_off;

    logic [FIELD_W-1:0] span_base;
    logic [FIELD_W-1:0] span_len;

    coalescing_interval_tracker dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    interval_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    // receiver stall pattern with long hold-off on request
    initial
    begin
        int mode;
        m_tready = 1'b0;
        mode = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
                m_tready <= 1'b0;
            else if ($urandom_range(0, 63) == 0)
                mode = $urandom_range(0, 2);
            else if (mode == 0)
                m_tready <= 1'b1;
            else if (mode == 1)
                m_tready <= $urandom_range(0, 3) != 0;
            else
                m_tready <= $urandom_range(0, 3) == 0;
        end
    end

    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic [FIELD_W-1:0] pos,
                                input logic [FIELD_W-1:0] len);
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {len, pos};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic pause_sender();
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6))
            @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (80)
            @(posedge clk);
    endtask

    task automatic write_file_size(input logic [FIELD_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [FIELD_W-1:0] rand_wide();
        logic [63:0] w;
        w = {$urandom(), $urandom()} >> $urandom_range(0, 47);
        return w[FIELD_W-1:0];
    endfunction

    task automatic random_request();
        int sel;
        logic [KIND_W-1:0] kind;
        logic [FIELD_W-1:0] pos, len;
        sel = $urandom_range(0, 99);
        pos = span_base + FIELD_W'($urandom_range(0, 2000));
        len = FIELD_W'($urandom_range(0, 300));
        if (sel < 50) begin
            kind = KIND_ADD;
        end else if (sel < 88) begin
            kind = KIND_QUERY;
        end else if (sel < 91) begin
            kind = KIND_CLEAR;
        end else if (sel < 93) begin
            kind = KIND_NOP;
            pos = rand_wide();
            len = rand_wide();
        end else begin
            kind = KIND_W'($urandom_range(0, 1));
            pos = rand_wide();
            len = rand_wide();
        end
        send_request(kind, pos, len);
    endtask

    initial
    begin
        int burst;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = KIND_ADD;
        cfg_valid = 1'b0;
        cfg_data = '0;
        hold_off = 1'b0;
        span_base = '0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_file_size(48'd1000);
        send_request(KIND_QUERY, 48'd0, 48'd10);
        send_request(KIND_ADD, 48'd0, 48'd0);
        send_request(KIND_ADD, 48'd500, 48'd500);
        send_request(KIND_ADD, 48'd100, 48'd100);
        send_request(KIND_ADD, 48'd200, 48'd300);
        send_request(KIND_ADD, 48'd0, 48'd150);
        send_request(KIND_ADD, 48'd0, 48'd150);
        send_request(KIND_QUERY, 48'd990, 48'd50);
        send_request(KIND_QUERY, 48'd10, 48'd0);
        send_request(KIND_QUERY, 48'd1000, 48'd1);
        send_request(KIND_NOP, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_request(KIND_CLEAR, 48'd0, 48'd0);
        send_request(KIND_ADD, 48'hFFFF_FFFF_FFF0, 48'hFFFF_FFFF_FFFF);
        send_request(KIND_ADD, 48'hFFFF_FFFF_FFFF, 48'd5);
        send_request(KIND_QUERY, 48'hFFFF_FFFF_FFFE, 48'hFFFF_FFFF_FFFF);
        send_request(KIND_ADD, 48'd0, 48'hFFFF_FFFF_FFFF);
        drain();
        write_file_size(48'hFFFF_FFFF_FFFF);
        send_request(KIND_QUERY, 48'd5, 48'd1);
        send_request(KIND_CLEAR, 48'd0, 48'd0);
        // fill the table, then one more disjoint add overflows
        for (int k = 0; k < 65; k++)
        begin
            send_request(KIND_ADD, FIELD_W'(10 * k), 48'd3);
            if ($urandom_range(0, 3) == 0)
                pause_sender();
        end
        send_request(KIND_ADD, 48'd9000, 48'd1);
        send_request(KIND_ADD, 48'd0, 48'd700);
        send_request(KIND_CLEAR, 48'd0, 48'd0);

        for (int phase = 0; phase < 4; phase++)
        begin
            drain();
            if (phase == 1)
                write_file_size('0);
            else
                write_file_size(FIELD_W'($urandom_range(1, 2300)));
            if (phase == 0)
            begin
                fork
                begin
                    hold_off = 1'b1;
                    repeat (400)
                        @(posedge clk);
                    hold_off = 1'b0;
                end
                join_none
            end
            span_base = phase == 3 ? 48'hFFFF_FFFF_F000 : '0;
            for (int n = 0; n < 135; n += burst)
            begin
                burst = $urandom_range(1, 20);
                for (int b = 0; b < burst; b++)
                    random_request();
                if ($urandom_range(0, 2) != 0)
                    pause_sender();
            end
        end
        drain();

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
